@@ rtl/core/ray_refraction_snell_core_macros.svh @@
// shared assertion macros for the refraction core checker
`ifndef RAY_REFRACTION_SNELL_CORE_MACROS_SVH
`define RAY_REFRACTION_SNELL_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define RRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/rrs_pkg.sv @@
package rrs_pkg;

    // main pipeline
    localparam int NUM_STAGES = 24;
    localparam int LAST_STAGE = NUM_STAGES - 1;

    // reciprocal of the index: 2^32 / ior, one quotient bit per step
    localparam int DIV_BITS   = 33;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;

    // square root of the discriminant, one root bit per step
    localparam int SQ_BITS    = 32;
    localparam int SQ_STEPS   = 4;
    localparam int SQ_STAGES  = SQ_BITS / SQ_STEPS;

    // stages that do work in the main pipeline
    localparam int ST_ETA     = DIV_STAGES;        // reciprocal is ready
    localparam int ST_ETA2    = ST_ETA + 1;
    localparam int ST_DISC    = ST_ETA2 + 1;       // feeds the root unit
    localparam int ST_K       = ST_DISC + SQ_STAGES + 1;
    localparam int ST_KN      = ST_K + 1;
    localparam int ST_SUM     = ST_KN + 1;

    typedef struct packed {
        logic [2:0][15:0]   inc;
        logic [2:0][16:0]   nrm;
        logic [2:0][31:0]   prod;
        logic signed [33:0] c28;
        logic               leaving;
        logic [15:0]        ior;
        logic [31:0]        m;
        logic [63:0]        msq;
        logic signed [25:0] rc;
        logic [31:0]        eta;
        logic signed [23:0] om;
        logic [39:0]        eta2;
        logic signed [58:0] ecp;
        logic [2:0][48:0]   sa;
        logic signed [63:0] disc;
        logic               tx;
        logic signed [34:0] ec;
        logic signed [35:0] k;
        logic [2:0][52:0]   kn;
        logic [2:0][58:0]   sum;
        logic [2:0][15:0]   res;
    } t_ray;

endpackage

@@ rtl/core/rrs_recip.sv @@
module rrs_recip import rrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_ior,
    output logic [31:0] o_eta
);

    logic [15:0] r_ior [DIV_STAGES];
    logic [15:0] r_rem [DIV_STAGES];
    logic [32:0] r_quo [DIV_STAGES];
    logic [15:0] n_ior [DIV_STAGES];
    logic [15:0] n_rem [DIV_STAGES];
    logic [32:0] n_quo [DIV_STAGES];

    always_comb begin
        logic [15:0] v_ior;
        logic [15:0] v_rem;
        logic [32:0] v_quo;
        logic [16:0] v_trial;
        int          v_b;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                v_ior = i_ior;
                v_rem = '0;
                v_quo = '0;
            end else begin
                v_ior = r_ior[s-1];
                v_rem = r_rem[s-1];
                v_quo = r_quo[s-1];
            end
            for (int t = 0; t < DIV_STEPS; t++) begin
                v_b = DIV_BITS - 1 - s * DIV_STEPS - t;
                if (v_b >= 0) begin
                    // numerator is a single one at the top bit
                    v_trial = {v_rem, 1'(v_b == DIV_BITS - 1)};
                    if (v_trial >= {1'b0, v_ior}) begin
                        v_rem = 16'(v_trial - {1'b0, v_ior});
                        v_quo = {v_quo[31:0], 1'b1};
                    end else begin
                        v_rem = v_trial[15:0];
                        v_quo = {v_quo[31:0], 1'b0};
                    end
                end
            end
            n_ior[s] = v_ior;
            n_rem[s] = v_rem;
            n_quo[s] = v_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ior <= n_ior;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // saturate 2^32 to all ones
    assign o_eta = r_quo[DIV_STAGES-1][32] ? '1 : r_quo[DIV_STAGES-1][31:0];

endmodule

@@ rtl/core/rrs_isqrt.sv @@
module rrs_isqrt import rrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [63:0] r_rad  [SQ_STAGES];
    logic [35:0] r_rem  [SQ_STAGES];
    logic [31:0] r_root [SQ_STAGES];
    logic [63:0] n_rad  [SQ_STAGES];
    logic [35:0] n_rem  [SQ_STAGES];
    logic [31:0] n_root [SQ_STAGES];

    always_comb begin
        logic [63:0] v_rad;
        logic [35:0] v_rem;
        logic [31:0] v_root;
        logic [35:0] v_trial;
        int          v_j;
        for (int s = 0; s < SQ_STAGES; s++) begin
            if (s == 0) begin
                v_rad  = i_rad;
                v_rem  = '0;
                v_root = '0;
            end else begin
                v_rad  = r_rad[s-1];
                v_rem  = r_rem[s-1];
                v_root = r_root[s-1];
            end
            for (int t = 0; t < SQ_STEPS; t++) begin
                v_j = s * SQ_STEPS + t;
                // bring down the next pair of radicand bits
                v_rem   = {v_rem[33:0], v_rad[63 - 2 * v_j -: 2]};
                v_trial = 36'({v_root, 2'b01});
                if (v_rem >= v_trial) begin
                    v_rem  = v_rem - v_trial;
                    v_root = {v_root[30:0], 1'b1};
                end else begin
                    v_root = {v_root[30:0], 1'b0};
                end
            end
            n_rad[s]  = v_rad;
            n_rem[s]  = v_rem;
            n_root[s] = v_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_root = r_root[SQ_STAGES-1];

endmodule

@@ rtl/core/ray_refraction_snell_core.sv @@
// throughput: one beat per cycle, 24 register stages under one shared stall
// the reciprocal of the index (9 stages) and the square root (8 stages) set the depth
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
// reset (synchronous, active low) clears the stage valid bits only
module ray_refraction_snell_core import rrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_incident_x,
    input  logic [15:0] i_incident_y,
    input  logic [15:0] i_incident_z,
    input  logic [15:0] i_normal_x,
    input  logic [15:0] i_normal_y,
    input  logic [15:0] i_normal_z,
    input  logic [15:0] i_index_of_refraction,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_refracted_x,
    output logic [15:0] o_refracted_y,
    output logic [15:0] o_refracted_z,
    output logic        o_transmitted
);

    t_ray r_p [NUM_STAGES];
    t_ray n_p [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_v;

    logic        w_en;
    logic [15:0] w_ior;
    logic [31:0] w_recip;
    logic [63:0] w_rad;
    logic [31:0] w_root;
    logic [2:0][15:0] w_inc;
    logic [2:0][15:0] w_nrm;

    // the whole pipe advances unless a finished beat is held at the output
    assign w_en    = !r_v[LAST_STAGE] || !i_stall;
    assign o_stall = r_v[LAST_STAGE] && i_stall;

    assign w_inc = {i_incident_z, i_incident_y, i_incident_x};
    assign w_nrm = {i_normal_z, i_normal_y, i_normal_x};

    // an index of zero counts as one lsb
    assign w_ior = (i_index_of_refraction == '0) ? 16'd1 : i_index_of_refraction;

    // 1/ior in q.20, runs beside stages 0 to 8
    rrs_recip u_recip (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ior (w_ior),
        .o_eta (w_recip)
    );

    // sqrt of the discriminant, runs beside the stages after ST_DISC;
    // a reflected ray feeds zero, its root is never used
    assign w_rad = r_p[ST_DISC].tx ? 64'(r_p[ST_DISC].disc) : '0;

    rrs_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (w_rad),
        .o_root (w_root)
    );

    always_comb begin
        logic signed [31:0] v_a32, v_b32;
        logic signed [33:0] v_c;
        logic signed [58:0] v_e59, v_r59;
        logic signed [48:0] v_e49, v_i49;
        logic signed [63:0] v_d64;
        logic signed [52:0] v_k53, v_n53;
        logic signed [58:0] v_s;
        logic signed [38:0] v_o;
        logic [63:0]        v_eta64;

        // by default every stage takes over its predecessor
        n_p[0] = '0;
        for (int i = 1; i < NUM_STAGES; i++) begin
            n_p[i] = r_p[i-1];
        end

        // stage 0: capture and per-axis products of the dot product
        n_p[0].ior = w_ior;
        for (int a = 0; a < 3; a++) begin
            n_p[0].inc[a] = w_inc[a];
            n_p[0].nrm[a] = 17'($signed(w_nrm[a]));
            v_a32 = 32'($signed(w_inc[a]));
            v_b32 = 32'($signed(w_nrm[a]));
            n_p[0].prod[a] = v_a32 * v_b32;
        end

        // stage 1: cos in q.28, flip for a ray leaving the medium
        v_c = 34'($signed(r_p[0].prod[0])) + 34'($signed(r_p[0].prod[1]))
            + 34'($signed(r_p[0].prod[2]));
        n_p[1].leaving = !v_c[33] && (v_c != '0);
        n_p[1].c28     = n_p[1].leaving ? -v_c : v_c;
        for (int a = 0; a < 3; a++) begin
            n_p[1].nrm[a] = n_p[1].leaving ? 17'(-$signed(r_p[0].nrm[a])) : r_p[0].nrm[a];
        end

        // stage 2: cos squared and cos rounded to q.20
        n_p[2].m   = 32'(-r_p[1].c28);
        n_p[2].msq = 64'(n_p[2].m) * 64'(n_p[2].m);
        v_c        = r_p[1].c28 + 34'sd128;
        n_p[2].rc  = 26'(v_c >>> 8);

        // eta in q.20 and 1 - cos^2 in q.14
        n_p[ST_ETA].eta = r_p[ST_ETA-1].leaving ? {8'b0, r_p[ST_ETA-1].ior, 8'b0} : w_recip;
        n_p[ST_ETA].om  = 24'sd16384 - $signed({2'b00, r_p[ST_ETA-1].msq[63:42]});

        // eta squared, eta*cos and eta*incident
        v_eta64          = 64'(r_p[ST_ETA].eta);
        n_p[ST_ETA2].eta2 = 40'((v_eta64 * v_eta64) >> 24);
        v_e59            = $signed(59'(r_p[ST_ETA].eta));
        v_r59            = 59'(r_p[ST_ETA].rc);
        n_p[ST_ETA2].ecp = v_e59 * v_r59;
        v_e49            = $signed(49'(r_p[ST_ETA].eta));
        for (int a = 0; a < 3; a++) begin
            v_i49 = 49'($signed(r_p[ST_ETA].inc[a]));
            n_p[ST_ETA2].sa[a] = v_e49 * v_i49;
        end

        // discriminant in q.30 and eta*cos rounded to q.15
        v_d64 = $signed(64'(r_p[ST_ETA2].eta2)) * 64'(r_p[ST_ETA2].om);
        n_p[ST_DISC].disc = 64'sh4000_0000 - v_d64;
        n_p[ST_DISC].tx   = !n_p[ST_DISC].disc[63] && (n_p[ST_DISC].disc != '0);
        v_e59 = r_p[ST_ETA2].ecp + 59'sd16777216;
        n_p[ST_DISC].ec = 35'(v_e59 >>> 25);

        // k = eta*cos + sqrt(disc), root arrives aligned with this stage
        n_p[ST_K].k = 36'(r_p[ST_K-1].ec) + $signed(36'(w_root));

        // k times the normal per axis
        v_k53 = 53'(r_p[ST_K].k);
        for (int a = 0; a < 3; a++) begin
            v_n53 = 53'($signed(r_p[ST_K].nrm[a]));
            n_p[ST_KN].kn[a] = v_k53 * v_n53;
        end

        // eta*I - k*n in q.34, k*n shifted left by 5 to align
        for (int a = 0; a < 3; a++) begin
            n_p[ST_SUM].sum[a] = 59'($signed(r_p[ST_KN].sa[a]))
                               - (59'($signed(r_p[ST_KN].kn[a])) <<< 5);
        end

        // round to q.14 and saturate, zero for total internal reflection
        for (int a = 0; a < 3; a++) begin
            v_s = $signed(r_p[ST_SUM].sum[a]) + 59'sd524288;
            v_o = 39'(v_s >>> 20);
            if (!r_p[ST_SUM].tx) begin
                n_p[LAST_STAGE].res[a] = '0;
            end else if (v_o > 39'sd32767) begin
                n_p[LAST_STAGE].res[a] = 16'h7FFF;
            end else if (v_o < -39'sd32768) begin
                n_p[LAST_STAGE].res[a] = 16'h8000;
            end else begin
                n_p[LAST_STAGE].res[a] = 16'(v_o);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NUM_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p <= n_p;
        end
    end

    assign o_valid       = r_v[LAST_STAGE];
    assign o_refracted_x = r_p[LAST_STAGE].res[0];
    assign o_refracted_y = r_p[LAST_STAGE].res[1];
    assign o_refracted_z = r_p[LAST_STAGE].res[2];
    assign o_transmitted = r_p[LAST_STAGE].tx;

endmodule

@@ rtl/core/rrs_checker.sv @@
`include "ray_refraction_snell_core_macros.svh"

module rrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_refracted_x,
    input logic [15:0] o_refracted_y,
    input logic [15:0] o_refracted_z,
    input logic        o_transmitted
);

    // a held output beat stays
    `RRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // input is stalled only while an output beat is held back
    `RRS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // total internal reflection gives a zero vector
    `RRS_ASSERT_NOW(a_tir_zero, i_clk, i_rst_n, o_valid && !o_transmitted,
        o_refracted_x == 16'h0 && o_refracted_y == 16'h0 && o_refracted_z == 16'h0)

    // a frozen pipe keeps its output beat unchanged
    `RRS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall,
        $stable(o_refracted_x) && $stable(o_refracted_y) && $stable(o_refracted_z)
        && $stable(o_transmitted))

endmodule

bind ray_refraction_snell_core rrs_checker u_rrs_checker (.*);
